// ===== rtl/tmcr_pkg.sv =====
// Shared types and constants of the text mode character raster unit.
package tmcr_pkg;

   localparam int MEM_AW     = 11;
   localparam int MEM_DEPTH  = 2048;
   localparam int DATA_W     = 8;
   localparam int FUNC_W     = 2;
   localparam int COL_W      = 7;
   localparam int LINE_W     = 4;
   localparam int ROW_W      = 5;
   localparam int FRAME_W    = 4;
   localparam int CODE_W     = 7;
   localparam int FLASH_BIT  = 7;
   localparam int BLINK_BIT  = 3;

   localparam logic [DATA_W-1:0]  SPACE_CODE  = 8'h20;
   localparam logic [FRAME_W-1:0] FRAME_RESET = 4'd1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_WRITE_VRAM = 2'd0,
      FUNC_WRITE_CROM = 2'd1,
      FUNC_FETCH      = 2'd2
   } func_type;

   // Raster position and frame phase that belong to one fetch.
   typedef struct packed {
      logic [MEM_AW-1:0] vram_addr;
      logic [LINE_W-1:0] scanline;
      logic              blank;
      logic              blink_phase;
      logic              last_in_line;
      logic              last_in_frame;
   } raster_pos_type;

endpackage

// ===== rtl/tmcr_if.sv =====
// Request and response channel interfaces of the text mode character raster unit.
interface tmcr_req_if;
   logic                           valid;
   logic                           ready;
   logic [tmcr_pkg::FUNC_W-1:0]    func;
   logic [tmcr_pkg::MEM_AW-1:0]    address;
   logic [tmcr_pkg::DATA_W-1:0]    write_data;

   modport source (output valid, output func, output address, output write_data, input ready);
   modport sink   (input valid, input func, input address, input write_data, output ready);
endinterface

interface tmcr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [tmcr_pkg::DATA_W-1:0]    pixels;
   logic                           last_in_line;
   logic                           last_in_frame;

   modport source (output valid, output pixels, output last_in_line, output last_in_frame,
                   input ready);
   modport sink   (input valid, input pixels, input last_in_line, input last_in_frame,
                   output ready);
endinterface

// ===== rtl/tmcr_ram.sv =====
// Generic single-port synchronous RAM with a registered, read-first output.
module tmcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/tmcr_raster.sv =====
// Raster counters: column, scan line, text row, frame count and video RAM address.
module tmcr_raster #(
   parameter int COLUMNS       = 80,
   parameter int ROWS          = 25,
   parameter int LINES_PER_ROW = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   output tmcr_pkg::raster_pos_type pos
);

   localparam int AddrW  = tmcr_pkg::MEM_AW;
   localparam int ColW   = tmcr_pkg::COL_W;
   localparam int LineW  = tmcr_pkg::LINE_W;
   localparam int RowW   = tmcr_pkg::ROW_W;
   localparam int FrameW = tmcr_pkg::FRAME_W;

   localparam logic [ColW-1:0]  LastCol   = ColW'(COLUMNS - 1);
   localparam logic [LineW-1:0] LastLine  = LineW'(LINES_PER_ROW - 1);
   localparam logic [RowW-1:0]  LastRow   = RowW'(ROWS - 1);
   localparam logic [AddrW-1:0] RowStride = AddrW'(COLUMNS);

   logic [ColW-1:0]   column_ff, column_in;
   logic [LineW-1:0]  scanline_ff, scanline_in;
   logic [RowW-1:0]   row_ff, row_in;
   logic [FrameW-1:0] frame_ff, frame_in;
   logic [AddrW-1:0]  row_base_ff, row_base_in;

   logic eol;
   logic last_line;
   logic last_row;

   assign eol       = (column_ff == LastCol);
   assign last_line = (scanline_ff == LastLine);
   assign last_row  = (row_ff == LastRow);

   // The row base steps by one row of characters, so no multiply is needed.
   assign pos.vram_addr     = row_base_ff + AddrW'(column_ff);
   assign pos.scanline      = scanline_ff;
   assign pos.blank         = last_line;
   assign pos.blink_phase   = frame_ff[tmcr_pkg::BLINK_BIT];
   assign pos.last_in_line  = eol;
   assign pos.last_in_frame = eol && last_line && last_row;

   always_comb begin
      column_in   = column_ff;
      scanline_in = scanline_ff;
      row_in      = row_ff;
      frame_in    = frame_ff;
      row_base_in = row_base_ff;
      if (step) begin
         if (!eol) begin
            column_in = column_ff + 1'b1;
         end else begin
            column_in = '0;
            if (!last_line) begin
               scanline_in = scanline_ff + 1'b1;
            end else begin
               scanline_in = '0;
               if (!last_row) begin
                  row_in      = row_ff + 1'b1;
                  row_base_in = row_base_ff + RowStride;
               end else begin
                  row_in      = '0;
                  row_base_in = '0;
                  frame_in    = frame_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff   <= '0;
         scanline_ff <= '0;
         row_ff      <= '0;
         frame_ff    <= tmcr_pkg::FRAME_RESET;
         row_base_ff <= '0;
      end else begin
         column_ff   <= column_in;
         scanline_ff <= scanline_in;
         row_ff      <= row_in;
         frame_ff    <= frame_in;
         row_base_ff <= row_base_in;
      end
   end

endmodule

// ===== rtl/text_mode_char_raster_unit.sv =====
// Top level of the text mode character raster unit.
// Each request either writes a byte into the video RAM or the character ROM, or fetches
// the next eight-pixel byte of the raster, bit 7 leftmost; the unused code does nothing.
// One request is taken per clock cycle while req_if.ready is high. A fetch passes through
// the video RAM read and then the character ROM read, each registered, before its response
// is shown. Both memories are single-port, and each request uses each port at most once,
// so the sustained rate is one request per cycle while responses are taken. After reset
// the video RAM is cleared to zero, one entry per cycle over all 2048 entries; req_if.ready
// stays low during that time. A stalled response holds one fetch in the output stage and
// one more request in the middle stage before the request side is held off.
module text_mode_char_raster_unit #(
   parameter int COLUMNS       = 80,
   parameter int ROWS          = 25,
   parameter int LINES_PER_ROW = 10
) (
   input  logic              clock,
   input  logic              reset,
   tmcr_req_if.sink          req_if,
   tmcr_rsp_if.source        rsp_if
);

   localparam int AddrW = tmcr_pkg::MEM_AW;
   localparam int DataW = tmcr_pkg::DATA_W;

   // Clearing pass over the video RAM.
   logic             clear_active_ff, clear_active_in;
   logic [AddrW-1:0] clear_addr_ff, clear_addr_in;

   // Middle stage: video RAM data is valid here for a fetch.
   logic                     s1_valid_ff, s1_valid_in;
   tmcr_pkg::func_type       s1_func_ff;
   logic [AddrW-1:0]         s1_address_ff;
   logic [DataW-1:0]         s1_data_ff;
   tmcr_pkg::raster_pos_type s1_pos_ff;

   // Output stage: character ROM data is valid here.
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_blank_ff;
   logic rsp_eol_ff;
   logic rsp_eof_ff;

   tmcr_pkg::raster_pos_type pos;
   tmcr_pkg::func_type       req_func;

   logic s2_free, s1_move, s1_free, accept, req_fetch, s1_fetch;

   logic             vram_en, vram_we;
   logic [AddrW-1:0] vram_addr;
   logic [DataW-1:0] vram_wdata, vram_rdata;

   logic             crom_en, crom_we;
   logic [AddrW-1:0] crom_addr;
   logic [DataW-1:0] crom_rdata;
   logic [DataW-1:0] code;

   assign req_func  = tmcr_pkg::func_type'(req_if.func);
   assign s2_free   = !rsp_valid_ff || rsp_if.ready;
   assign s1_move   = s1_valid_ff && s2_free;
   assign s1_free   = !s1_valid_ff || s1_move;
   assign req_if.ready = s1_free && !clear_active_ff;
   assign accept    = req_if.valid && req_if.ready;
   assign req_fetch = accept && (req_func == tmcr_pkg::FUNC_FETCH);
   assign s1_fetch  = (s1_func_ff == tmcr_pkg::FUNC_FETCH);

   tmcr_raster #(
      .COLUMNS       (COLUMNS),
      .ROWS          (ROWS),
      .LINES_PER_ROW (LINES_PER_ROW)
   ) u_raster (
      .clock (clock),
      .reset (reset),
      .step  (req_fetch),
      .pos   (pos)
   );

   // Video RAM port: clearing pass, request writes and fetch reads.
   always_comb begin
      vram_en    = 1'b0;
      vram_we    = 1'b0;
      vram_addr  = pos.vram_addr;
      vram_wdata = req_if.write_data;
      if (clear_active_ff) begin
         vram_en    = 1'b1;
         vram_we    = 1'b1;
         vram_addr  = clear_addr_ff;
         vram_wdata = '0;
      end else if (accept) begin
         case (req_func)
            tmcr_pkg::FUNC_WRITE_VRAM: begin
               vram_en   = 1'b1;
               vram_we   = 1'b1;
               vram_addr = req_if.address;
            end
            tmcr_pkg::FUNC_FETCH: begin
               vram_en = !pos.blank;
            end
            default: begin
               vram_en = 1'b0;
            end
         endcase
      end
   end

   tmcr_ram #(
      .WIDTH (DataW),
      .DEPTH (tmcr_pkg::MEM_DEPTH)
   ) u_vram (
      .clock (clock),
      .en    (vram_en),
      .we    (vram_we),
      .addr  (vram_addr),
      .wdata (vram_wdata),
      .rdata (vram_rdata)
   );

   // A flashing character shows as a space during the blink phase.
   always_comb begin
      code = vram_rdata;
      if (vram_rdata[tmcr_pkg::FLASH_BIT] && s1_pos_ff.blink_phase) begin
         code = tmcr_pkg::SPACE_CODE;
      end
   end

   // Character ROM writes wait until the middle stage so that they stay in order with reads.
   assign crom_we   = (s1_func_ff == tmcr_pkg::FUNC_WRITE_CROM);
   assign crom_en   = s1_move && (crom_we || !s1_pos_ff.blank);
   assign crom_addr = crom_we ? s1_address_ff
                              : {code[tmcr_pkg::CODE_W-1:0], s1_pos_ff.scanline};

   tmcr_ram #(
      .WIDTH (DataW),
      .DEPTH (tmcr_pkg::MEM_DEPTH)
   ) u_crom (
      .clock (clock),
      .en    (crom_en),
      .we    (crom_we),
      .addr  (crom_addr),
      .wdata (s1_data_ff),
      .rdata (crom_rdata)
   );

   always_comb begin
      clear_active_in = clear_active_ff;
      clear_addr_in   = clear_addr_ff;
      if (clear_active_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == '1) begin
            clear_active_in = 1'b0;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      if (accept && (req_func inside {tmcr_pkg::FUNC_WRITE_CROM, tmcr_pkg::FUNC_FETCH})) begin
         s1_valid_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_move && s1_fetch) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_active_ff <= 1'b1;
         clear_addr_ff   <= '0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         clear_active_ff <= clear_active_in;
         clear_addr_ff   <= clear_addr_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_func_ff    <= req_func;
         s1_address_ff <= req_if.address;
         s1_data_ff    <= req_if.write_data;
         s1_pos_ff     <= pos;
      end
      if (s1_move && s1_fetch) begin
         rsp_blank_ff <= s1_pos_ff.blank;
         rsp_eol_ff   <= s1_pos_ff.last_in_line;
         rsp_eof_ff   <= s1_pos_ff.last_in_frame;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.pixels        = rsp_blank_ff ? '0 : crom_rdata;
   assign rsp_if.last_in_line  = rsp_eol_ff;
   assign rsp_if.last_in_frame = rsp_eof_ff;

endmodule

// ===== rtl/tmcr_check.sv =====
// Port checker of the text mode character raster unit and its bind statement.
module tmcr_check (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [tmcr_pkg::DATA_W-1:0]   rsp_pixels,
   input logic                          rsp_last_in_line,
   input logic                          rsp_last_in_frame
);

   // The clearing pass holds off requests straight after reset.
   assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request taken during the video RAM clearing pass");

   // No response can come out of an emptied pipeline.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response shown straight after reset");

   // A stalled response keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && !rsp_ready |=>
                    rsp_valid && $stable(rsp_pixels) && $stable(rsp_last_in_line) &&
                    $stable(rsp_last_in_frame))
      else $error("stalled response changed");

   // The end of a frame is always the end of a scan line.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && rsp_last_in_frame |-> rsp_last_in_line)
      else $error("frame ended away from the end of a scan line");

endmodule

bind text_mode_char_raster_unit tmcr_check u_tmcr_check (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_if.ready),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_pixels        (rsp_if.pixels),
   .rsp_last_in_line  (rsp_if.last_in_line),
   .rsp_last_in_frame (rsp_if.last_in_frame)
);

// ===== tb/sv/text_mode_char_raster_unit_tb.sv =====
// Self-checking testbench of the text mode character raster unit.
module text_mode_char_raster_unit_tb;

   localparam int COLUMNS       = 80;
   localparam int ROWS          = 25;
   localparam int LINES_PER_ROW = 10;
   localparam int IDLE_PERCENT  = 21;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 20;
   localparam int GLYPH_CODES   = 5;
   localparam longint CYCLE_LIMIT = 40_000;

   localparam int MEM_AW    = tmcr_pkg::MEM_AW;
   localparam int MEM_DEPTH = tmcr_pkg::MEM_DEPTH;
   localparam int DATA_W    = tmcr_pkg::DATA_W;
   localparam int FUNC_W    = tmcr_pkg::FUNC_W;
   localparam int COL_W     = tmcr_pkg::COL_W;
   localparam int LINE_W    = tmcr_pkg::LINE_W;
   localparam int ROW_W     = tmcr_pkg::ROW_W;
   localparam int FRAME_W   = tmcr_pkg::FRAME_W;
   localparam int CODE_W    = tmcr_pkg::CODE_W;
   localparam int FLASH_BIT = tmcr_pkg::FLASH_BIT;
   localparam int BLINK_BIT = tmcr_pkg::BLINK_BIT;

   // The function code that the block must ignore.
   localparam logic [FUNC_W-1:0]  FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic [DATA_W-1:0] pixels;
      logic              last_in_line;
      logic              last_in_frame;
   } raster_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tmcr_req_if req_if ();
   tmcr_rsp_if rsp_if ();

   text_mode_char_raster_unit #(
      .COLUMNS       (COLUMNS),
      .ROWS          (ROWS),
      .LINES_PER_ROW (LINES_PER_ROW)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // Shadow copy of the display state, advanced as each request is accepted.
   logic [DATA_W-1:0]  vram_shadow  [MEM_DEPTH];
   logic [DATA_W-1:0]  glyph_shadow [MEM_DEPTH];
   logic [COL_W-1:0]   col_pos;
   logic [LINE_W-1:0]  line_pos;
   logic [ROW_W-1:0]   row_pos;
   logic [FRAME_W-1:0] frame_no;

   raster_byte_type pending_bytes [$];

   bit     idle_on = 1'b1;
   int     rsp_hold_cycles = 0;
   int     mismatch_count = 0;
   longint cycle_count = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Character codes whose glyph rows are loaded; the video RAM only ever holds these.
   function automatic logic [CODE_W-1:0] loaded_code(input int n);
      case (n)
         0:       return 7'h00;
         1:       return 7'h01;
         2:       return 7'h20;
         3:       return 7'h41;
         default: return 7'h7f;
      endcase
   endfunction

   // A loaded character, with or without its flash bit.
   function automatic logic [DATA_W-1:0] random_char();
      return {1'($urandom_range(0, 1)), loaded_code(int'($urandom_range(0, GLYPH_CODES - 1)))};
   endfunction

   function automatic logic [MEM_AW-1:0] raster_vram_addr();
      return MEM_AW'(row_pos * COLUMNS + col_pos);
   endfunction

   // Glyph entry that the next fetch reads, with the flash rule applied.
   function automatic logic [MEM_AW-1:0] glyph_addr_now();
      logic [DATA_W-1:0] code;
      code = vram_shadow[raster_vram_addr()];
      if (code[FLASH_BIT] && frame_no[BLINK_BIT])
         code = tmcr_pkg::SPACE_CODE;
      return {code[CODE_W-1:0], line_pos};
   endfunction

   task automatic track_request(input logic [FUNC_W-1:0] func,
                                input logic [MEM_AW-1:0] addr,
                                input logic [DATA_W-1:0] data);
      raster_byte_type next_byte;
      case (func)
         tmcr_pkg::FUNC_WRITE_VRAM: vram_shadow[addr] = data;
         tmcr_pkg::FUNC_WRITE_CROM: glyph_shadow[addr] = data;
         tmcr_pkg::FUNC_FETCH: begin
            next_byte.last_in_line  = (col_pos == COLUMNS - 1);
            next_byte.last_in_frame = next_byte.last_in_line &&
                                      (line_pos == LINES_PER_ROW - 1) &&
                                      (row_pos == ROWS - 1);
            // The last scan line of every text row is blank.
            next_byte.pixels = (line_pos == LINES_PER_ROW - 1) ?
                               '0 : glyph_shadow[glyph_addr_now()];
            pending_bytes.push_back(next_byte);
            if (!next_byte.last_in_line) begin
               col_pos = col_pos + 1'b1;
            end else begin
               col_pos = '0;
               if (line_pos != LINES_PER_ROW - 1) begin
                  line_pos = line_pos + 1'b1;
               end else begin
                  line_pos = '0;
                  if (row_pos != ROWS - 1) begin
                     row_pos = row_pos + 1'b1;
                  end else begin
                     row_pos  = '0;
                     frame_no = frame_no + 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_request(input logic [FUNC_W-1:0] func,
                               input logic [MEM_AW-1:0] addr,
                               input logic [DATA_W-1:0] data);
      while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.func       <= func;
      req_if.address    <= addr;
      req_if.write_data <= data;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      track_request(func, addr, data);
   endtask

   task automatic wait_drain();
      req_if.valid <= 1'b0;
      do
         @(posedge clock);
      while (pending_bytes.size() != 0);
   endtask

   // Glyph rows of every loaded character are written first, so that no fetch reads an
   // unwritten entry.
   task automatic test_load_glyphs();
      for (int c = 0; c < GLYPH_CODES; c++)
         for (int line = 0; line < LINES_PER_ROW - 1; line++)
            send_request(tmcr_pkg::FUNC_WRITE_CROM, {loaded_code(c), LINE_W'(line)},
                         DATA_W'($urandom_range(0, 255)));
   endtask

   task automatic test_directed();
      idle_on = 1'b0;
      send_request(tmcr_pkg::FUNC_WRITE_VRAM, '0, 8'hff);
      send_request(tmcr_pkg::FUNC_WRITE_VRAM, '1, 8'h00);
      send_request(tmcr_pkg::FUNC_WRITE_VRAM, '1, 8'hff);
      send_request(tmcr_pkg::FUNC_WRITE_CROM, '0, 8'h00);
      send_request(tmcr_pkg::FUNC_WRITE_CROM, '1, 8'hff);
      send_request(tmcr_pkg::FUNC_WRITE_CROM, 11'h7f0, 8'ha5);
      // The unused code must leave no trace.
      send_request(FUNC_UNUSED, '1, 8'hff);
      send_request(FUNC_UNUSED, '0, 8'h00);
      send_request(tmcr_pkg::FUNC_FETCH, '1, 8'hff);
      send_request(tmcr_pkg::FUNC_FETCH, '0, 8'h00);
      // A write straight before the fetch that reads it.
      send_request(tmcr_pkg::FUNC_WRITE_VRAM, raster_vram_addr(), 8'h41);
      send_request(tmcr_pkg::FUNC_WRITE_CROM, glyph_addr_now(), 8'h3c);
      send_request(tmcr_pkg::FUNC_FETCH, '0, 8'h00);
      // A flashing character while the blink phase is clear.
      send_request(tmcr_pkg::FUNC_WRITE_VRAM, raster_vram_addr(), 8'hc1);
      send_request(tmcr_pkg::FUNC_WRITE_CROM, glyph_addr_now(), 8'h81);
      send_request(tmcr_pkg::FUNC_FETCH, 11'h555, 8'h5a);
      send_request(tmcr_pkg::FUNC_FETCH, 11'h2aa, 8'ha5);
      send_request(tmcr_pkg::FUNC_FETCH, '0, 8'h00);
      wait_drain();
      idle_on = 1'b1;
   endtask

   task automatic test_random_traffic(input int count);
      int done;
      int choice;
      logic [MEM_AW-1:0] addr;
      done = 0;
      while (done < count) begin
         choice = $urandom_range(0, 99);
         addr   = MEM_AW'($urandom_range(0, MEM_DEPTH - 1));
         if (choice < 45) begin
            send_request(tmcr_pkg::FUNC_FETCH, addr, DATA_W'($urandom_range(0, 255)));
            done++;
         end else if (choice < 70) begin
            if ($urandom_range(0, 2) == 0)
               addr = raster_vram_addr();
            send_request(tmcr_pkg::FUNC_WRITE_VRAM, addr, random_char());
            done++;
         end else if (choice < 90) begin
            if ($urandom_range(0, 2) == 0)
               addr = glyph_addr_now();
            send_request(tmcr_pkg::FUNC_WRITE_CROM, addr, DATA_W'($urandom_range(0, 255)));
            done++;
         end else begin
            send_request(FUNC_UNUSED, addr, DATA_W'($urandom_range(0, 255)));
         end
      end
   endtask

   // The receiver holds off while fetches keep coming, then the sender waits for
   // every outstanding byte before it goes on.
   task automatic test_backpressure();
      rsp_hold_cycles = HOLD_CYCLES;
      for (int n = 0; n < 40; n++)
         send_request(tmcr_pkg::FUNC_FETCH, MEM_AW'($urandom_range(0, MEM_DEPTH - 1)),
                      DATA_W'($urandom_range(0, 255)));
      wait_drain();
      for (int n = 0; n < 10; n++)
         send_request(tmcr_pkg::FUNC_FETCH, '0, 8'h00);
   endtask

   // Mixed traffic with neither side ever pausing.
   task automatic test_streaming();
      idle_on = 1'b0;
      test_random_traffic(120);
      idle_on = 1'b1;
   endtask

   always @(posedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_hold_cycles--;
      end else begin
         rsp_if.ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin : check_responses
      raster_byte_type wanted;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_bytes.size() == 0) begin
            $error("pixels: response with nothing outstanding, actual %h", rsp_if.pixels);
            mismatch_count++;
         end else begin
            wanted = pending_bytes.pop_front();
            if (rsp_if.pixels !== wanted.pixels) begin
               $error("pixels: expected %h, actual %h", wanted.pixels, rsp_if.pixels);
               mismatch_count++;
            end
            if (rsp_if.last_in_line !== wanted.last_in_line) begin
               $error("last_in_line: expected %b, actual %b",
                      wanted.last_in_line, rsp_if.last_in_line);
               mismatch_count++;
            end
            if (rsp_if.last_in_frame !== wanted.last_in_frame) begin
               $error("last_in_frame: expected %b, actual %b",
                      wanted.last_in_frame, rsp_if.last_in_frame);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("text_mode_char_raster_unit_tb: FAIL");
         $finish;
      end
   end

   initial begin
      req_if.valid      = 1'b0;
      req_if.func       = tmcr_pkg::FUNC_FETCH;
      req_if.address    = '0;
      req_if.write_data = '0;
      rsp_if.ready      = 1'b0;
      for (int a = 0; a < MEM_DEPTH; a++)
         vram_shadow[a] = '0;
      col_pos  = '0;
      line_pos = '0;
      row_pos  = '0;
      frame_no = tmcr_pkg::FRAME_RESET;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_load_glyphs();
      test_directed();
      test_random_traffic(180);
      test_backpressure();
      test_streaming();
      wait_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_bytes.size() == 0)
         $display("text_mode_char_raster_unit_tb: PASS");
      else
         $display("text_mode_char_raster_unit_tb: FAIL");
      $finish;
   end

endmodule
